// ----- rtl/frc_pkg.sv -----
`timescale 1ns / 1ps
package frc_pkg;

  localparam int LANES = 8;
  localparam int LANE_W = 3;
  localparam int CNT_W = 8;
  localparam int PAGE_SHIFT = 12;
  localparam int PGN_W = 32 - PAGE_SHIFT;
  localparam logic [CNT_W-1:0] RESERVED_COUNT = 8'd100;
  localparam logic [CNT_W-1:0] MAX_COUNT = 8'd255;

  typedef enum logic [2:0] {
    K_INIT  = 3'd0,
    K_ALLOC = 3'd1,
    K_FREE  = 3'd2,
    K_SHARE = 3'd3,
    K_QUERY = 3'd4
  } kind_t;

  typedef enum logic [2:0] {
    ST_OK     = 3'd0,
    ST_BELOW  = 3'd1,
    ST_NOMEM  = 3'd2,
    ST_BEYOND = 3'd3,
    ST_DOUBLE = 3'd4,
    ST_SAT    = 3'd5
  } status_t;

  typedef enum logic [1:0] {
    CFG_LOW_BASE  = 2'd0,
    CFG_FREE_BASE = 2'd1,
    CFG_MEM_END   = 2'd2
  } cfg_idx_t;

  typedef enum logic [2:0] {
    U_FILL  = 3'd0,
    U_ALLOC = 3'd1,
    U_DEC   = 3'd2,
    U_INC   = 3'd3,
    U_READ  = 3'd4
  } unit_op_t;

  typedef struct packed {
    logic              found;
    logic [LANE_W-1:0] lane;
    logic [CNT_W-1:0]  count;
    status_t           status;
  } unit_rsp_t;

endpackage

// ----- rtl/frc_ram.sv -----
`timescale 1ns / 1ps
module frc_ram #(
  parameter int DEPTH = 512,
  parameter int AW = 9,
  parameter int DW = 64
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic [AW-1:0] raddr,
  output logic [DW-1:0] rdata
);

  logic [DW-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- rtl/frc_unit.sv -----
`timescale 1ns / 1ps
module frc_unit #(
  parameter int NUM_FRAMES = 4096,
  parameter int ROW_W = 9
) (
  input  frc_pkg::unit_op_t                              op,
  input  logic [ROW_W-1:0]                               row,
  input  logic [frc_pkg::LANE_W-1:0]                     lane,
  input  logic [frc_pkg::PGN_W-1:0]                      first,
  input  logic [frc_pkg::PGN_W-1:0]                      cnt,
  input  logic [frc_pkg::LANES*frc_pkg::CNT_W-1:0]       rd_row,
  output logic [frc_pkg::LANES*frc_pkg::CNT_W-1:0]       wr_row,
  output frc_pkg::unit_rsp_t                             rsp
);

  localparam int IDX_W = ROW_W + frc_pkg::LANE_W;

  logic [frc_pkg::LANES-1:0][frc_pkg::CNT_W-1:0] rr;
  logic [frc_pkg::LANES-1:0][frc_pkg::CNT_W-1:0] wr;
  logic [IDX_W-1:0]           jidx;
  logic [frc_pkg::PGN_W-1:0]  jx;
  logic [frc_pkg::CNT_W-1:0]  cur;

  assign rr = rd_row;
  assign wr_row = wr;

  always_comb begin
    wr = rr;
    rsp.found = 1'b0;
    rsp.lane = '0;
    rsp.count = '0;
    rsp.status = frc_pkg::ST_OK;
    jidx = '0;
    jx = '0;
    cur = rr[lane];
    for (int l = 0; l < frc_pkg::LANES; l++) begin
      jidx = {row, frc_pkg::LANE_W'(l)};
      if (({1'b0, jidx} < (IDX_W+1)'(NUM_FRAMES)) && (rr[l] == '0)) begin
        rsp.found = 1'b1;
        rsp.lane = frc_pkg::LANE_W'(l);
      end
    end
    unique case (op)
      frc_pkg::U_FILL: begin
        for (int l = 0; l < frc_pkg::LANES; l++) begin
          jx = frc_pkg::PGN_W'({row, frc_pkg::LANE_W'(l)});
          if ((jx >= first) && ((jx - first) < cnt)) begin
            wr[l] = '0;
          end else begin
            wr[l] = frc_pkg::RESERVED_COUNT;
          end
        end
      end
      frc_pkg::U_ALLOC: begin
        if (rsp.found) begin
          wr[rsp.lane] = frc_pkg::CNT_W'(1);
          rsp.count = frc_pkg::CNT_W'(1);
        end else begin
          rsp.status = frc_pkg::ST_NOMEM;
        end
      end
      frc_pkg::U_DEC: begin
        if (cur == '0) begin
          rsp.status = frc_pkg::ST_DOUBLE;
        end else begin
          wr[lane] = cur - frc_pkg::CNT_W'(1);
          rsp.count = cur - frc_pkg::CNT_W'(1);
        end
      end
      frc_pkg::U_INC: begin
        if (cur == frc_pkg::MAX_COUNT) begin
          rsp.status = frc_pkg::ST_SAT;
          rsp.count = frc_pkg::MAX_COUNT;
        end else begin
          wr[lane] = cur + frc_pkg::CNT_W'(1);
          rsp.count = cur + frc_pkg::CNT_W'(1);
        end
      end
      frc_pkg::U_READ: begin
        rsp.count = cur;
      end
      default: begin
        rsp.count = '0;
      end
    endcase
  end

endmodule

// ----- rtl/page_frame_refcount_allocator.sv -----
`timescale 1ns / 1ps
// Counts sit in a RAM of NUM_FRAMES/8 rows, eight per row; one row is read per cycle.
// Free, share, query pass LOCATE, FETCH, MODIFY, RESP (LOCATE goes to RESP for an address
// outside the frames); init SETUP, a SWEEP over all rows, RESP; alloc SCAN down the rows to
// a free lane or row 0, then RESP; others go to RESP. s_tready is high only in IDLE, so one
// item at a time; RESP waits while m_tready holds back a result. Reset: synchronous, clears
// config to defaults, then a pass over all rows zeroes all counts while s_tready stays low.
module page_frame_refcount_allocator #(
  parameter int NUM_FRAMES = 4096
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // addr[31:0]
  input  logic [7:0]  s_tuser,   // kind[2:0], zero[7:3]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [47:0] m_tdata,   // page_addr[31:0], ref_count[39:32], status[42:40], zero[47:43]
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  localparam int IDX_W = $clog2(NUM_FRAMES);
  localparam int ROW_W = IDX_W - frc_pkg::LANE_W;
  localparam int ROWS = (NUM_FRAMES + frc_pkg::LANES - 1) / frc_pkg::LANES;
  localparam int DW = frc_pkg::LANES * frc_pkg::CNT_W;

  typedef enum logic [8:0] {
    S_CLEAR  = 9'b000000001,
    S_IDLE   = 9'b000000010,
    S_LOCATE = 9'b000000100,
    S_SETUP  = 9'b000001000,
    S_SWEEP  = 9'b000010000,
    S_SCAN   = 9'b000100000,
    S_FETCH  = 9'b001000000,
    S_MODIFY = 9'b010000000,
    S_RESP   = 9'b100000000
  } state_t;

  state_t state;
  logic [31:0] low_mem_base;
  logic [31:0] free_base;
  logic [31:0] mem_end;
  logic [2:0]  kind_q;
  logic [31:0] addr_q;
  logic [IDX_W-1:0] idx_q;
  logic [ROW_W-1:0] sweep_row;
  logic [ROW_W-1:0] scan_row;
  logic [ROW_W-1:0] chk_row;
  logic             chk_valid;
  logic [frc_pkg::PGN_W-1:0] first_q;
  logic [frc_pkg::PGN_W-1:0] cnt_q;
  logic [31:0] res_addr;
  logic [frc_pkg::CNT_W-1:0] res_cnt;
  frc_pkg::status_t res_st;
  logic        resp_load;

  logic [31:0] loc_off;
  logic [31:0] init_off;
  logic [31:0] init_span;

  frc_pkg::unit_op_t  u_op;
  logic [ROW_W-1:0]   u_row;
  logic [DW-1:0]      rd_row;
  logic [DW-1:0]      wr_row;
  frc_pkg::unit_rsp_t rsp;
  logic               ram_we;
  logic [ROW_W-1:0]   ram_waddr;
  logic [ROW_W-1:0]   ram_raddr;

  assign s_tready = (state == S_IDLE);
  assign cfg_ready = 1'b1;
  assign loc_off = addr_q - low_mem_base;
  assign init_off = free_base - low_mem_base;
  assign init_span = mem_end - free_base;
  assign resp_load = (state == S_RESP) && (!m_tvalid || m_tready);

  always_comb begin
    u_op = frc_pkg::U_READ;
    u_row = idx_q[IDX_W-1:frc_pkg::LANE_W];
    ram_we = 1'b0;
    ram_waddr = idx_q[IDX_W-1:frc_pkg::LANE_W];
    ram_raddr = idx_q[IDX_W-1:frc_pkg::LANE_W];
    unique case (state)
      S_CLEAR, S_SWEEP: begin
        u_op = frc_pkg::U_FILL;
        u_row = sweep_row;
        ram_we = 1'b1;
        ram_waddr = sweep_row;
      end
      S_SCAN: begin
        u_op = frc_pkg::U_ALLOC;
        u_row = chk_row;
        ram_we = chk_valid && rsp.found;
        ram_waddr = chk_row;
        ram_raddr = scan_row;
      end
      S_MODIFY: begin
        ram_we = 1'b1;
        if (kind_q == frc_pkg::K_FREE) begin
          u_op = frc_pkg::U_DEC;
        end else if (kind_q == frc_pkg::K_SHARE) begin
          u_op = frc_pkg::U_INC;
        end
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  frc_ram #(
    .DEPTH (ROWS),
    .AW    (ROW_W),
    .DW    (DW)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (wr_row),
    .raddr (ram_raddr),
    .rdata (rd_row)
  );

  frc_unit #(
    .NUM_FRAMES (NUM_FRAMES),
    .ROW_W      (ROW_W)
  ) u_unit (
    .op     (u_op),
    .row    (u_row),
    .lane   (idx_q[frc_pkg::LANE_W-1:0]),
    .first  (first_q),
    .cnt    (cnt_q),
    .rd_row (rd_row),
    .wr_row (wr_row),
    .rsp    (rsp)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      low_mem_base <= 32'h0010_0000;
      free_base <= 32'h0010_0000;
      mem_end <= 32'h0100_0000;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        frc_pkg::CFG_LOW_BASE:  low_mem_base <= cfg_data;
        frc_pkg::CFG_FREE_BASE: free_base <= cfg_data;
        frc_pkg::CFG_MEM_END:   mem_end <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      sweep_row <= '0;
      first_q <= '0;
      cnt_q <= '1;
      chk_valid <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      if (resp_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        S_CLEAR: begin
          if (sweep_row == ROW_W'(ROWS - 1)) begin
            state <= S_IDLE;
          end else begin
            sweep_row <= sweep_row + ROW_W'(1);
          end
        end
        S_IDLE: begin
          if (s_tvalid) begin
            kind_q <= s_tuser[2:0];
            addr_q <= s_tdata;
            res_addr <= '0;
            res_cnt <= '0;
            res_st <= frc_pkg::ST_OK;
            unique case (s_tuser[2:0])
              frc_pkg::K_INIT: state <= S_SETUP;
              frc_pkg::K_ALLOC: begin
                scan_row <= ROW_W'(ROWS - 1);
                chk_valid <= 1'b0;
                state <= S_SCAN;
              end
              frc_pkg::K_FREE, frc_pkg::K_SHARE, frc_pkg::K_QUERY: state <= S_LOCATE;
              default: state <= S_RESP;
            endcase
          end
        end
        S_LOCATE: begin
          idx_q <= loc_off[frc_pkg::PAGE_SHIFT +: IDX_W];
          if (addr_q < low_mem_base) begin
            res_st <= frc_pkg::ST_BELOW;
            state <= S_RESP;
          end else if ((addr_q >= mem_end) ||
                       (loc_off[31:frc_pkg::PAGE_SHIFT] >= frc_pkg::PGN_W'(NUM_FRAMES))) begin
            res_st <= frc_pkg::ST_BEYOND;
            state <= S_RESP;
          end else begin
            state <= S_FETCH;
          end
        end
        S_SETUP: begin
          first_q <= init_off[31:frc_pkg::PAGE_SHIFT];
          cnt_q <= (mem_end > free_base) ? init_span[31:frc_pkg::PAGE_SHIFT] : '0;
          sweep_row <= '0;
          state <= S_SWEEP;
        end
        S_SWEEP: begin
          if (sweep_row == ROW_W'(ROWS - 1)) begin
            state <= S_RESP;
          end else begin
            sweep_row <= sweep_row + ROW_W'(1);
          end
        end
        S_SCAN: begin
          if (chk_valid && rsp.found) begin
            res_addr <= low_mem_base +
                        (32'({chk_row, rsp.lane}) << frc_pkg::PAGE_SHIFT);
            res_cnt <= rsp.count;
            state <= S_RESP;
          end else if (chk_valid && (chk_row == '0)) begin
            res_st <= frc_pkg::ST_NOMEM;
            state <= S_RESP;
          end else begin
            chk_valid <= 1'b1;
            chk_row <= scan_row;
            if (scan_row != '0) begin
              scan_row <= scan_row - ROW_W'(1);
            end
          end
        end
        S_FETCH: begin
          state <= S_MODIFY;
        end
        S_MODIFY: begin
          res_cnt <= rsp.count;
          res_st <= rsp.status;
          state <= S_RESP;
        end
        S_RESP: begin
          if (resp_load) begin
            m_tdata <= {5'b0, res_st, res_cnt, res_addr};
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef ASSERT_OFF
  a_no_accept_in_clear: assert property (@(posedge clk) disable iff (rst)
    (state == S_CLEAR) |-> !s_tready)
    else $error("input beat accepted during clearing pass");

  a_result_from_resp: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(state == S_RESP))
    else $error("result loaded outside response state");

  a_no_write_idle: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE) |-> !ram_we)
    else $error("count RAM written while idle");

  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> (state != S_IDLE) && (state != S_CLEAR))
    else $error("accepted beat did not start work");
`endif

endmodule
